@@ hw/rtl/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and codes of the round-robin task scheduler
// Command and slot state codes, request and response beats.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam logic [2:0] CMD_ENQUEUE  = 3'd0;
    localparam logic [2:0] CMD_TICK     = 3'd1;
    localparam logic [2:0] CMD_SCHEDULE = 3'd2;
    localparam logic [2:0] CMD_YIELD    = 3'd3;
    localparam logic [2:0] CMD_SLEEP    = 3'd4;
    localparam logic [2:0] CMD_EXIT     = 3'd5;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_CREATE  = 3'd0;
    localparam logic [ST_W-1:0] ST_READY   = 3'd1;
    localparam logic [ST_W-1:0] ST_RUNNING = 3'd2;
    localparam logic [ST_W-1:0] ST_WAITING = 3'd3;
    localparam logic [ST_W-1:0] ST_EXIT    = 3'd4;

    localparam int LEFT_W    = 29;   // sleep countdown width
    localparam int MS_W      = 32;
    localparam int DIV_W     = MS_W + 1;
    localparam int SLEEP_BIAS = 9;   // rounds the ms-to-tick division up
    // divide by ten: halve, then multiply by the reciprocal of five
    localparam logic [MS_W-1:0] DIV5_RECIP = 32'hCCCC_CCCD;
    localparam int DIV5_SHIFT = 34;

    typedef struct packed {
        logic [2:0]      cmd;
        logic [5:0]      task_id;
        logic [MS_W-1:0] sleep_ms;
    } t_req;

    typedef struct packed {
        logic [5:0] run_task;
        logic       next_is_idle;
        logic       switched;
        logic [6:0] ready_count;
        logic [6:0] woken_count;
    } t_rsp;

endpackage

@@ hw/rtl/rrts_ram.sv @@
// ----------------------------------------------------------------------------
// rrts_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/round_robin_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_scheduler: per-CPU task scheduler with a sleep list
// Ready queue (woken sleepers go to its head) and ordered sleep list threaded
// through one link memory; slot states and sleep countdowns in their own memories.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  ----------------------
//  command   in         start high while busy low     i_req  (rrts_pkg::t_req)
//  result    out        o_valid, one cycle, no stall  o_rsp  (rrts_pkg::t_rsp)
//
//  States per command beat, accept to result strobe: enqueue EQ, FIN;
//    unknown codes FIN; tick FIN with an empty sleep list, else TK per sleeper
//    (one sleeper per cycle through the link memory), then FIN; schedule CHK,
//    TAKE, PUT if requeueing, FIN; exit CHK, TAKE, FIN; yield CHK, then FIN or as
//    schedule; sleep CHK, FIN if no task runs, else DIV (ms / 10), SLP, TAKE, FIN.
//  Reset is synchronous, active low; slot states read as create until written.
//  A new command is taken in the cycle the previous result is on the strobe.
//
module round_robin_task_scheduler #(
    parameter int MAX_TASKS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rrts_pkg::t_req i_req,
    output logic          o_valid,
    output rrts_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EQ   = 4'd1;
    localparam logic [3:0] S_TK   = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_SLP  = 4'd5;
    localparam logic [3:0] S_TAKE = 4'd6;
    localparam logic [3:0] S_PUT  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    // control and list registers
    logic [3:0]    r_fsm, n_fsm;
    logic [2:0]    r_cmd, n_cmd;
    logic [5:0]    r_tid, n_tid;
    logic          r_prev_idle, n_prev_idle;
    logic [AW-1:0] r_prev_slot, n_prev_slot;
    logic [AW-1:0] r_rdy_head, n_rdy_head, r_rdy_tail, n_rdy_tail;
    logic [CW-1:0] r_rdy_len, n_rdy_len;
    logic [AW-1:0] r_slp_head, n_slp_head, r_slp_tail, n_slp_tail;
    logic [CW-1:0] r_slp_len, n_slp_len;
    logic [AW-1:0] r_run, n_run;
    logic          r_idle, n_idle;
    logic          r_req, n_req;
    // tick walk
    logic [AW-1:0] r_node, n_node, r_nh, n_nh, r_nt, n_nt;
    logic [CW-1:0] r_cnt, n_cnt, r_nl, n_nl, r_woken, n_woken;
    // divide by ten
    logic [rrts_pkg::DIV_W-1:0] r_dq, n_dq;
    // result register
    logic          r_out_vld, n_out_vld;
    rrts_pkg::t_rsp r_out, n_out;
    // slot state valid bits
    logic [MAX_TASKS-1:0] r_st_vld;
    logic          r_st_rv;

    // memory ports
    logic                        st_we, lk_we, lf_we;
    logic [AW-1:0]               st_waddr, lk_waddr, lf_waddr, st_raddr, lk_raddr;
    logic [rrts_pkg::ST_W-1:0]   st_wdata, st_rdata, st_eff;
    logic [AW-1:0]               lk_wdata, lk_rdata;
    logic [rrts_pkg::LEFT_W-1:0] lf_wdata, lf_rdata;

    rrts_ram #(.WIDTH(rrts_pkg::ST_W), .DEPTH(MAX_TASKS)) u_state_ram (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata)
    );

    rrts_ram #(.WIDTH(AW), .DEPTH(MAX_TASKS)) u_link_ram (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_raddr(lk_raddr), .o_rdata(lk_rdata)
    );

    rrts_ram #(.WIDTH(rrts_pkg::LEFT_W), .DEPTH(MAX_TASKS)) u_left_ram (
        .i_clk(i_clk), .i_we(lf_we), .i_waddr(lf_waddr), .i_wdata(lf_wdata),
        .i_raddr(lk_raddr), .o_rdata(lf_rdata)
    );

    // never-written slots read as create
    assign st_eff = r_st_rv ? st_rdata : rrts_pkg::ST_CREATE;

    logic accept;
    assign accept  = start && (r_fsm == S_IDLE);
    assign busy    = (r_fsm != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

    // Read addresses: the slot state of the enqueued slot or the current
    // task; the link of the ready head, or the sleep chain during a tick.
    always_comb begin
        st_raddr = r_run;
        lk_raddr = r_rdy_head;
        if (r_fsm == S_IDLE) begin
            if (i_req.cmd == rrts_pkg::CMD_ENQUEUE) begin
                st_raddr = AW'(i_req.task_id);
            end
            if (i_req.cmd == rrts_pkg::CMD_TICK) begin
                lk_raddr = r_slp_head;
            end
        end else if (r_fsm == S_TK) begin
            lk_raddr = lk_rdata;
        end
    end

    logic                        cur, wake, tid_ok;
    logic [2*rrts_pkg::MS_W-1:0] div_prod;
    logic [rrts_pkg::LEFT_W-1:0] left;

    always_comb begin
        n_fsm = r_fsm;   n_cmd = r_cmd;   n_tid = r_tid;
        n_prev_idle = r_prev_idle;   n_prev_slot = r_prev_slot;
        n_rdy_head = r_rdy_head;   n_rdy_tail = r_rdy_tail;   n_rdy_len = r_rdy_len;
        n_slp_head = r_slp_head;   n_slp_tail = r_slp_tail;   n_slp_len = r_slp_len;
        n_run = r_run;   n_idle = r_idle;   n_req = r_req;
        n_node = r_node;   n_nh = r_nh;   n_nt = r_nt;   n_nl = r_nl;
        n_cnt = r_cnt;   n_woken = r_woken;
        n_dq = r_dq;
        n_out_vld = 1'b0;   n_out = r_out;
        st_we = 1'b0;   st_waddr = r_run;   st_wdata = rrts_pkg::ST_READY;
        lk_we = 1'b0;   lk_waddr = r_rdy_tail;   lk_wdata = r_run;
        lf_we = 1'b0;   lf_waddr = r_node;   lf_wdata = '0;
        cur    = !r_idle && (st_eff == rrts_pkg::ST_RUNNING);
        tid_ok = (32'(r_tid) < MAX_TASKS);
        left   = lf_rdata;
        wake   = (left <= rrts_pkg::LEFT_W'(1));
        div_prod = 64'(r_dq[rrts_pkg::DIV_W-1:1]) * 64'(rrts_pkg::DIV5_RECIP);

        case (r_fsm)
            S_IDLE: begin
                if (accept) begin
                    n_cmd       = i_req.cmd;
                    n_tid       = i_req.task_id;
                    n_prev_idle = r_idle;
                    n_prev_slot = r_run;
                    n_woken     = '0;
                    n_dq        = rrts_pkg::DIV_W'(i_req.sleep_ms)
                                + rrts_pkg::DIV_W'(rrts_pkg::SLEEP_BIAS);
                    n_node      = r_slp_head;
                    n_cnt       = r_slp_len;
                    n_nh        = '0;
                    n_nt        = '0;
                    n_nl        = '0;
                    case (i_req.cmd)
                        rrts_pkg::CMD_ENQUEUE: n_fsm = S_EQ;
                        rrts_pkg::CMD_TICK:    n_fsm = (r_slp_len == '0) ? S_FIN : S_TK;
                        rrts_pkg::CMD_SCHEDULE, rrts_pkg::CMD_YIELD,
                        rrts_pkg::CMD_SLEEP, rrts_pkg::CMD_EXIT: n_fsm = S_CHK;
                        default:               n_fsm = S_FIN;
                    endcase
                end
            end

            S_EQ: begin
                // append at the ready tail unless already listed
                if (tid_ok && st_eff != rrts_pkg::ST_READY &&
                    st_eff != rrts_pkg::ST_WAITING) begin
                    st_we    = 1'b1;
                    st_waddr = AW'(r_tid);
                    st_wdata = rrts_pkg::ST_READY;
                    if (r_rdy_len == '0) begin
                        n_rdy_head = AW'(r_tid);
                    end else begin
                        lk_we    = 1'b1;
                        lk_waddr = r_rdy_tail;
                        lk_wdata = AW'(r_tid);
                    end
                    n_rdy_tail = AW'(r_tid);
                    n_rdy_len  = r_rdy_len + CW'(1);
                end
                n_fsm = S_FIN;
            end

            S_TK: begin
                // one sleeper per cycle; its link and count arrived this cycle
                lf_we    = 1'b1;
                lf_waddr = r_node;
                if (wake) begin
                    lf_wdata = '0;
                    st_we    = 1'b1;
                    st_waddr = r_node;
                    st_wdata = rrts_pkg::ST_READY;
                    if (r_rdy_len == '0) begin
                        n_rdy_tail = r_node;
                    end else begin
                        lk_we    = 1'b1;
                        lk_waddr = r_node;
                        lk_wdata = r_rdy_head;
                    end
                    n_rdy_head = r_node;
                    n_rdy_len  = r_rdy_len + CW'(1);
                    n_woken    = r_woken + CW'(1);
                end else begin
                    lf_wdata = left - rrts_pkg::LEFT_W'(1);
                    if (r_nl == '0) begin
                        n_nh = r_node;
                    end else begin
                        lk_we    = 1'b1;
                        lk_waddr = r_nt;
                        lk_wdata = r_node;
                    end
                    n_nt = r_node;
                    n_nl = r_nl + CW'(1);
                end
                n_node = lk_rdata;
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_slp_head = n_nh;
                    n_slp_tail = n_nt;
                    n_slp_len  = n_nl;
                    n_fsm      = S_FIN;
                end
            end

            S_CHK: begin
                n_req = 1'b0;
                case (r_cmd)
                    rrts_pkg::CMD_SLEEP: begin
                        n_fsm = cur ? S_DIV : S_FIN;
                    end
                    rrts_pkg::CMD_YIELD: begin
                        // a running task alone with an empty queue keeps running
                        if (cur && r_rdy_len == '0) begin
                            n_fsm = S_FIN;
                        end else begin
                            n_req = cur;
                            n_fsm = S_TAKE;
                        end
                    end
                    rrts_pkg::CMD_EXIT: begin
                        if (cur) begin
                            st_we    = 1'b1;
                            st_waddr = r_run;
                            st_wdata = rrts_pkg::ST_EXIT;
                        end
                        n_fsm = S_TAKE;
                    end
                    default: begin
                        n_req = cur;
                        n_fsm = S_TAKE;
                    end
                endcase
            end

            S_DIV: begin
                // halve the biased count, then divide by five through the reciprocal
                n_dq  = rrts_pkg::DIV_W'(div_prod[rrts_pkg::DIV5_SHIFT +: rrts_pkg::LEFT_W]);
                n_fsm = S_SLP;
            end

            S_SLP: begin
                // park the current task at the sleep tail
                lf_we    = 1'b1;
                lf_waddr = r_run;
                lf_wdata = r_dq[rrts_pkg::LEFT_W-1:0];
                st_we    = 1'b1;
                st_waddr = r_run;
                st_wdata = rrts_pkg::ST_WAITING;
                if (r_slp_len == '0) begin
                    n_slp_head = r_run;
                end else begin
                    lk_we    = 1'b1;
                    lk_waddr = r_slp_tail;
                    lk_wdata = r_run;
                end
                n_slp_tail = r_run;
                n_slp_len  = r_slp_len + CW'(1);
                n_fsm      = S_TAKE;
            end

            S_TAKE: begin
                // dequeue the ready head, or fall back to the idle task
                if (r_rdy_len != '0) begin
                    st_we      = 1'b1;
                    st_waddr   = r_rdy_head;
                    st_wdata   = rrts_pkg::ST_RUNNING;
                    n_run      = r_rdy_head;
                    n_idle     = 1'b0;
                    n_rdy_len  = r_rdy_len - CW'(1);
                    n_rdy_head = (r_rdy_len > CW'(1)) ? lk_rdata : '0;
                    if (r_rdy_len == CW'(1)) begin
                        n_rdy_tail = '0;
                    end
                end else begin
                    n_run  = '0;
                    n_idle = 1'b1;
                end
                n_fsm = r_req ? S_PUT : S_FIN;
            end

            S_PUT: begin
                // requeue the previous task at the ready tail
                st_we    = 1'b1;
                st_waddr = r_prev_slot;
                st_wdata = rrts_pkg::ST_READY;
                if (r_rdy_len == '0) begin
                    n_rdy_head = r_prev_slot;
                end else begin
                    lk_we    = 1'b1;
                    lk_waddr = r_rdy_tail;
                    lk_wdata = r_prev_slot;
                end
                n_rdy_tail = r_prev_slot;
                n_rdy_len  = r_rdy_len + CW'(1);
                n_fsm      = S_FIN;
            end

            S_FIN: begin
                n_out_vld          = 1'b1;
                n_out.run_task     = r_idle ? 6'd0 : 6'(r_run);
                n_out.next_is_idle = r_idle;
                n_out.switched     = (r_prev_idle != r_idle) ||
                                     (!r_idle && r_prev_slot != r_run);
                n_out.ready_count  = 7'(r_rdy_len);
                n_out.woken_count  = 7'(r_woken);
                n_fsm              = S_IDLE;
            end

            default: n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= S_IDLE;
            r_rdy_head <= '0;
            r_rdy_tail <= '0;
            r_rdy_len  <= '0;
            r_slp_head <= '0;
            r_slp_tail <= '0;
            r_slp_len  <= '0;
            r_run      <= '0;
            r_idle     <= 1'b1;
            r_out_vld  <= 1'b0;
            r_st_vld   <= '0;
            r_req      <= 1'b0;
        end else begin
            r_fsm      <= n_fsm;
            r_rdy_head <= n_rdy_head;
            r_rdy_tail <= n_rdy_tail;
            r_rdy_len  <= n_rdy_len;
            r_slp_head <= n_slp_head;
            r_slp_tail <= n_slp_tail;
            r_slp_len  <= n_slp_len;
            r_run      <= n_run;
            r_idle     <= n_idle;
            r_out_vld  <= n_out_vld;
            r_req      <= n_req;
            if (st_we) begin
                r_st_vld[st_waddr] <= 1'b1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_tid       <= n_tid;
        r_prev_idle <= n_prev_idle;
        r_prev_slot <= n_prev_slot;
        r_node      <= n_node;
        r_nh        <= n_nh;
        r_nt        <= n_nt;
        r_nl        <= n_nl;
        r_cnt       <= n_cnt;
        r_woken     <= n_woken;
        r_dq        <= n_dq;
        r_out       <= n_out;
        r_st_rv     <= r_st_vld[st_raddr];
    end

    // ---------------------------------------------------------------- checks
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |=> !r_out_vld)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("command beat accepted without going busy");

    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle |-> (r_run == '0))
        else $error("idle task current with a nonzero slot");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rdy_len == '0) |-> (r_rdy_head == '0 && r_rdy_tail == '0))
        else $error("empty ready queue with stale head or tail");

    a_ready_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_rdy_len) + 32'(r_slp_len) <= MAX_TASKS))
        else $error("more listed tasks than slots");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the round-robin task scheduler
// Drives command beats through start/busy and checks every result strobe
// against a behavioral model of the ready queue, sleep list and slot states.
// A short table of directed beats runs first, then random command mixes.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 64;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 1130;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    rrts_pkg::t_req i_req = '0;
    logic           o_valid;
    rrts_pkg::t_rsp o_rsp;

    always #4 i_clk = ~i_clk;

    round_robin_task_scheduler #(.MAX_TASKS(SLOTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_rsp(o_rsp)
    );

    // ---------------- scheduler model ----------------
    // Ready queue and sleep list are kept as SV queues; order is what matters.
    logic [5:0]                  rdy_q[$];
    logic [5:0]                  slp_q[$];
    logic [rrts_pkg::LEFT_W-1:0] left_cnt[SLOTS];
    logic [rrts_pkg::ST_W-1:0]   slot_st[SLOTS];
    logic [5:0]                  cur_slot;
    logic                        cur_idle;

    rrts_pkg::t_rsp rsp_pending[$];   // results still owed by the block
    int   n_errors;
    int   n_mism;

    function automatic logic cur_is_running();
        return !cur_idle && slot_st[cur_slot] == rrts_pkg::ST_RUNNING;
    endfunction

    function automatic void push_tail(logic [5:0] s);
        rdy_q.push_back(s);
        slot_st[s] = rrts_pkg::ST_READY;
    endfunction

    function automatic void take_head();
        if (rdy_q.size() == 0) begin
            cur_idle = 1'b1;
            cur_slot = '0;
        end else begin
            cur_slot = rdy_q.pop_front();
            cur_idle = 1'b0;
            slot_st[cur_slot] = rrts_pkg::ST_RUNNING;
        end
    endfunction

    function automatic void resched();
        logic       requeue;
        logic [5:0] prev;
        requeue = cur_is_running();
        prev = cur_slot;
        take_head();
        if (requeue) push_tail(prev);
    endfunction

    // Apply one command beat and return the scheduler view afterwards.
    function automatic rrts_pkg::t_rsp sched_apply(rrts_pkg::t_req r);
        rrts_pkg::t_rsp res;
        logic       p_idle;
        logic [5:0] p_slot;
        int         woken;
        logic [5:0] keep[$];
        logic [32:0] ticks;
        p_idle = cur_idle;
        p_slot = cur_slot;
        woken = 0;
        case (r.cmd)
            rrts_pkg::CMD_ENQUEUE: begin
                if (slot_st[r.task_id] != rrts_pkg::ST_READY &&
                    slot_st[r.task_id] != rrts_pkg::ST_WAITING)
                    push_tail(r.task_id);
            end
            rrts_pkg::CMD_TICK: begin
                // wake expired sleepers onto the ready head, in walk order
                foreach (slp_q[i]) begin
                    if (left_cnt[slp_q[i]] <= rrts_pkg::LEFT_W'(1)) begin
                        left_cnt[slp_q[i]] = '0;
                        rdy_q.push_front(slp_q[i]);
                        slot_st[slp_q[i]] = rrts_pkg::ST_READY;
                        woken++;
                    end else begin
                        left_cnt[slp_q[i]] = left_cnt[slp_q[i]] - rrts_pkg::LEFT_W'(1);
                        keep.push_back(slp_q[i]);
                    end
                end
                slp_q = keep;
            end
            rrts_pkg::CMD_SCHEDULE: resched();
            rrts_pkg::CMD_YIELD: begin
                if (cur_is_running()) push_tail(cur_slot);
                take_head();
            end
            rrts_pkg::CMD_SLEEP: begin
                if (cur_is_running()) begin
                    ticks = ({1'b0, r.sleep_ms} + 33'd9) / 33'd10;
                    left_cnt[cur_slot] = ticks[rrts_pkg::LEFT_W-1:0];
                    slot_st[cur_slot] = rrts_pkg::ST_WAITING;
                    slp_q.push_back(cur_slot);
                    take_head();
                end
            end
            rrts_pkg::CMD_EXIT: begin
                if (cur_is_running()) slot_st[cur_slot] = rrts_pkg::ST_EXIT;
                resched();
            end
            default: ;
        endcase
        res.run_task     = cur_idle ? 6'd0 : cur_slot;
        res.next_is_idle = cur_idle;
        res.switched     = (p_idle != cur_idle) || (!cur_idle && p_slot != cur_slot);
        res.ready_count  = 7'(rdy_q.size());
        res.woken_count  = 7'(woken);
        return res;
    endfunction

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        rrts_pkg::t_rsp want;
        if (i_rst_n && o_valid) begin
            if (rsp_pending.size() == 0) begin
                n_errors++;
                if (n_mism++ < 10) $display("unexpected result beat %p", o_rsp);
            end else begin
                want = rsp_pending.pop_front();
                if (o_rsp !== want) begin
                    n_errors++;
                    if (n_mism++ < 10) $display("mismatch: expected %p got %p", want, o_rsp);
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    int stall_cyc = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) stall_cyc <= 0;
        else stall_cyc <= stall_cyc + 1;
        if (stall_cyc >= WDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    typedef struct {
        rrts_pkg::t_req r;
        logic           has_fixed;
        rrts_pkg::t_rsp fixed;
    } t_row;

    t_row dir_rows[$];
    logic gaps_on;

    function automatic rrts_pkg::t_req mk(logic [2:0] c, logic [5:0] t, logic [31:0] ms);
        rrts_pkg::t_req r;
        r.cmd = c;
        r.task_id = t;
        r.sleep_ms = ms;
        return r;
    endfunction

    function automatic rrts_pkg::t_rsp mkr(logic [5:0] t, logic idl, logic sw,
                                           logic [6:0] rc, logic [6:0] wc);
        rrts_pkg::t_rsp x;
        x.run_task = t; x.next_is_idle = idl; x.switched = sw;
        x.ready_count = rc; x.woken_count = wc;
        return x;
    endfunction

    function automatic void add_row(rrts_pkg::t_req r, logic fx, rrts_pkg::t_rsp f);
        t_row w;
        w.r = r; w.has_fixed = fx; w.fixed = f;
        dir_rows.push_back(w);
    endfunction

    // Hand one beat to the block: optional idle burst, then hold start while it is busy.
    task automatic send_beat(rrts_pkg::t_req r, logic fx, rrts_pkg::t_rsp f);
        rrts_pkg::t_rsp want;
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        want = sched_apply(r);
        if (fx && want !== f) begin
            n_errors++;
            if (n_mism++ < 10) $display("table row disagrees: %p vs %p", f, want);
        end
        rsp_pending.push_back(want);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        i_req <= mk(3'($urandom), 6'($urandom), $urandom);
        // the block is busy for this edge anyway; keep one drive per time step
        @(posedge i_clk);
    endtask

    function automatic rrts_pkg::t_req rand_beat();
        int          sel;
        logic [31:0] ms;
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: ms = $urandom_range(0, 30);
            1: ms = $urandom_range(0, 200);
            2: ms = $urandom;
            default: ms = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
        endcase
        // keep sleeps short mostly so sleepers come back within the run
        if (ms > 200 && $urandom_range(0, 3) != 0) ms = $urandom_range(0, 60);
        if (sel < 25) return mk(rrts_pkg::CMD_ENQUEUE, 6'($urandom), ms);
        if (sel < 50) return mk(rrts_pkg::CMD_TICK, 6'($urandom), ms);
        if (sel < 65) return mk(rrts_pkg::CMD_SCHEDULE, 6'($urandom), ms);
        if (sel < 77) return mk(rrts_pkg::CMD_YIELD, 6'($urandom), ms);
        if (sel < 90) return mk(rrts_pkg::CMD_SLEEP, 6'($urandom), ms);
        if (sel < 97) return mk(rrts_pkg::CMD_EXIT, 6'($urandom), ms);
        return mk(3'($urandom_range(6, 7)), 6'($urandom), ms);
    endfunction

    initial begin
        rrts_pkg::t_rsp none;
        int   waited;
        none = '0;
        n_errors = 0;
        n_mism = 0;
        gaps_on = 1'b1;
        foreach (slot_st[i]) begin
            slot_st[i] = rrts_pkg::ST_CREATE;
            left_cnt[i] = '0;
        end
        cur_slot = '0;
        cur_idle = 1'b1;

        // schedule, sleep and exit while idle and empty, tick empty, unknown codes, enqueues
        add_row(mk(rrts_pkg::CMD_SCHEDULE, 6'd0, 32'd0), 1'b1,
                mkr(6'd0, 1'b1, 1'b0, 7'd0, 7'd0));
        add_row(mk(rrts_pkg::CMD_TICK, 6'd63, 32'hFFFF_FFFF), 1'b1,
                mkr(6'd0, 1'b1, 1'b0, 7'd0, 7'd0));
        add_row(mk(3'd6, 6'd5, 32'd1), 1'b1, mkr(6'd0, 1'b1, 1'b0, 7'd0, 7'd0));
        add_row(mk(3'd7, 6'd5, 32'd1), 1'b1, mkr(6'd0, 1'b1, 1'b0, 7'd0, 7'd0));
        add_row(mk(rrts_pkg::CMD_SLEEP, 6'd0, 32'd50), 1'b1,
                mkr(6'd0, 1'b1, 1'b0, 7'd0, 7'd0));
        add_row(mk(rrts_pkg::CMD_EXIT, 6'd0, 32'd0), 1'b1,
                mkr(6'd0, 1'b1, 1'b0, 7'd0, 7'd0));
        add_row(mk(rrts_pkg::CMD_ENQUEUE, 6'd0, 32'd0), 1'b1,
                mkr(6'd0, 1'b1, 1'b0, 7'd1, 7'd0));
        add_row(mk(rrts_pkg::CMD_ENQUEUE, 6'd63, 32'd0), 1'b1,
                mkr(6'd0, 1'b1, 1'b0, 7'd2, 7'd0));
        add_row(mk(rrts_pkg::CMD_ENQUEUE, 6'd63, 32'd0), 1'b1,
                mkr(6'd0, 1'b1, 1'b0, 7'd2, 7'd0));
        add_row(mk(rrts_pkg::CMD_SCHEDULE, 6'd0, 32'd0), 1'b1,
                mkr(6'd0, 1'b0, 1'b1, 7'd1, 7'd0));
        add_row(mk(rrts_pkg::CMD_YIELD, 6'd0, 32'd0), 1'b1,
                mkr(6'd63, 1'b0, 1'b1, 7'd1, 7'd0));
        // sleep extremes: zero ms, one over a multiple of ten, full range
        add_row(mk(rrts_pkg::CMD_SLEEP, 6'd0, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_ENQUEUE, 6'd63, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_SCHEDULE, 6'd0, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_SLEEP, 6'd0, 32'hFFFF_FFFF), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_ENQUEUE, 6'd7, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_SCHEDULE, 6'd0, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_SLEEP, 6'd0, 32'd11), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_TICK, 6'd0, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_TICK, 6'd0, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_ENQUEUE, 6'd42, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_SCHEDULE, 6'd0, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_EXIT, 6'd0, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_ENQUEUE, 6'd42, 32'd0), 1'b0, none);
        add_row(mk(rrts_pkg::CMD_YIELD, 6'd0, 32'd0), 1'b0, none);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_beat(dir_rows[i].r, dir_rows[i].has_fixed, dir_rows[i].fixed);
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k > N_RANDOM - 150) gaps_on = 1'b0;
            send_beat(rand_beat(), 1'b0, none);
        end

        waited = 0;
        while (rsp_pending.size() != 0 && waited < WDOG_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (80) @(posedge i_clk);
        if (n_errors == 0 && rsp_pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_ram.sv
hw/rtl/round_robin_task_scheduler.sv
dv/tb_top.sv
